@@ hw/rtl/iim_pkg.sv @@
// ----------------------------------------------------------------------------
// iim_pkg
// Shared types and codes for the interval insert and merge block.
// ----------------------------------------------------------------------------
package iim_pkg;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BUILD,
        ST_REPORT
    } iim_state_t;

    typedef enum logic [1:0] {
        PH_PRE,
        PH_POS,
        PH_MERGE,
        PH_POST
    } iim_phase_t;

    typedef struct packed {
        logic pop;
        logic push;
    } iim_shift_t;

endpackage

@@ hw/rtl/interval_insert_merge.sv @@
// ----------------------------------------------------------------------------
// interval_insert_merge
// Sorted table of disjoint closed intervals held in a ring of cells; an
// insert is merged in on one pass over the ring, then the table is reported.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  in      | input     | in_valid / in_stall | cmd, new_start, new_end
//  out     | output    | out_valid/out_stall | out_start, out_end, entry_valid,
//          |           |                     | last_entry, overflow
//
//  For an insert over N table entries, the merge unit at the head of the
//  ring takes one entry per cycle while rebuilding, then the report rotates
//  the ring once, one result per cycle unless out_stall holds it. A clear
//  empties the table. rst_n empties the table; entry data is not reset.
//  Output stalls hold the report; the last result may wait while the next
//  item is taken.
// ----------------------------------------------------------------------------
module interval_insert_merge
    import iim_pkg::*;
#(
    parameter int DEPTH       = 16,
    parameter int VALUE_WIDTH = 32
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          cmd,
    input  logic signed [VALUE_WIDTH-1:0] new_start,
    input  logic signed [VALUE_WIDTH-1:0] new_end,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [VALUE_WIDTH-1:0] out_start,
    output logic signed [VALUE_WIDTH-1:0] out_end,
    output logic                          entry_valid,
    output logic                          last_entry,
    output logic                          overflow
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);

    iim_state_t state_reg, state_next;
    iim_phase_t phase_reg, phase_next;

    logic [CW-1:0] rem_reg, rem_next;
    logic [CW-1:0] occ_reg, occ_next;
    logic [CW-1:0] rpt_reg, rpt_next;
    logic          ovf_reg, ovf_next;

    logic signed [VALUE_WIDTH-1:0] ins_s_reg, ins_s_next;
    logic signed [VALUE_WIDTH-1:0] ins_e_reg, ins_e_next;
    logic signed [VALUE_WIDTH-1:0] acc_s_reg, acc_s_next;
    logic signed [VALUE_WIDTH-1:0] acc_e_reg, acc_e_next;

    logic                          out_valid_reg, out_valid_next;
    logic signed [VALUE_WIDTH-1:0] out_s_reg, out_s_next;
    logic signed [VALUE_WIDTH-1:0] out_e_reg, out_e_next;
    logic                          out_ev_reg, out_ev_next;
    logic                          out_last_reg, out_last_next;
    logic                          out_ovf_reg, out_ovf_next;

    logic signed [VALUE_WIDTH-1:0] cell_s [DEPTH];
    logic signed [VALUE_WIDTH-1:0] cell_e [DEPTH];
    logic [DEPTH+1:0]              occ_ext;

    logic signed [VALUE_WIDTH-1:0] head_s, head_e, nxt_s;
    logic signed [VALUE_WIDTH-1:0] push_s, push_e;
    iim_shift_t                    shift_ctl;

    logic in_fire, ins_fire, clr_fire;
    logic have_head, have_next, full;
    logic in_build, at_pos, is_prev, merge_prev;
    logic pos_merge, pos_drop, pos_new, merge_more, build_done;
    logic out_load, rpt_last;

    assign in_stall = (state_reg != ST_IDLE);
    assign in_fire  = in_valid & ~in_stall;
    assign ins_fire = in_fire & (cmd == CMD_INSERT);
    assign clr_fire = in_fire & (cmd == CMD_CLEAR);

    // ring of cells
    assign occ_ext[0]       = 1'b1;
    assign occ_ext[DEPTH+1] = 1'b0;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic signed [VALUE_WIDTH-1:0] nx_s;
            logic signed [VALUE_WIDTH-1:0] nx_e;

            assign occ_ext[gi+1] = (CW'(gi) < occ_reg);

            if (gi < DEPTH - 1)
            begin : g_mid
                assign nx_s = cell_s[gi+1];
                assign nx_e = cell_e[gi+1];
            end
            else
            begin : g_end
                assign nx_s = cell_s[gi];
                assign nx_e = cell_e[gi];
            end

            iim_cell #(
                .VALUE_WIDTH (VALUE_WIDTH)
            ) u_cell (
                .clk       (clk),
                .ctl       (shift_ctl),
                .occ_left  (occ_ext[gi]),
                .occ_self  (occ_ext[gi+1]),
                .occ_right (occ_ext[gi+2]),
                .next_s    (nx_s),
                .next_e    (nx_e),
                .push_s    (push_s),
                .push_e    (push_e),
                .cell_s    (cell_s[gi]),
                .cell_e    (cell_e[gi])
            );
        end
    endgenerate

    assign head_s = cell_s[0];
    assign head_e = cell_e[0];
    assign nxt_s  = cell_s[1];

    // merge unit decisions
    always_comb
    begin
        have_head  = (rem_reg != '0);
        have_next  = (rem_reg > ONE_C);
        full       = (occ_reg == DEPTH_C);
        in_build   = (state_reg == ST_BUILD);
        is_prev    = ~(have_next && (nxt_s < ins_s_reg));
        at_pos     = in_build && ((phase_reg == PH_POS) ||
                     ((phase_reg == PH_PRE) && (!have_head || !(head_s < ins_s_reg))));
        merge_prev = in_build && (phase_reg == PH_PRE) && !at_pos && is_prev &&
                     (head_e >= ins_s_reg);
        pos_merge  = at_pos && have_head && (ins_e_reg >= head_s);
        pos_drop   = at_pos && !pos_merge && full;
        pos_new    = at_pos && !pos_merge && !full;
        merge_more = in_build && (phase_reg == PH_MERGE) && have_head &&
                     (acc_e_reg >= head_s);
        build_done = in_build && (phase_reg == PH_POST) && !have_head;
        out_load   = (state_reg == ST_REPORT) && (!out_valid_reg || !out_stall);
        rpt_last   = (occ_reg == '0) || (rpt_reg == occ_reg - ONE_C);
    end

    // phase next state
    always_comb
    begin
        phase_next = phase_reg;
        if (ins_fire)
        begin
            phase_next = PH_PRE;
        end
        else if (in_build)
        begin
            case (phase_reg)
                PH_PRE:
                begin
                    if (merge_prev || pos_merge)
                        phase_next = PH_MERGE;
                    else if (pos_drop || pos_new)
                        phase_next = PH_POST;
                    else if (!at_pos && is_prev)
                        phase_next = PH_POS;
                end
                PH_POS:
                begin
                    phase_next = pos_merge ? PH_MERGE : PH_POST;
                end
                PH_MERGE:
                begin
                    phase_next = merge_more ? PH_MERGE : PH_POST;
                end
                PH_POST:
                begin
                    phase_next = PH_POST;
                end
                default:
                begin
                    phase_next = PH_PRE;
                end
            endcase
        end
    end

    // top state next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (ins_fire)
                    state_next = ST_BUILD;
            end
            ST_BUILD:
            begin
                if (build_done)
                    state_next = ST_REPORT;
            end
            ST_REPORT:
            begin
                if (out_load && rpt_last)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ring control, accumulator and counters
    always_comb
    begin
        shift_ctl.pop  = 1'b0;
        shift_ctl.push = 1'b0;
        push_s         = head_s;
        push_e         = head_e;
        acc_s_next     = acc_s_reg;
        acc_e_next     = acc_e_reg;
        ins_s_next     = ins_s_reg;
        ins_e_next     = ins_e_reg;
        ovf_next       = ovf_reg;
        rem_next       = rem_reg;
        rpt_next       = rpt_reg;

        if (in_build)
        begin
            shift_ctl.pop  = ((phase_reg == PH_PRE) && !at_pos) || pos_merge ||
                             merge_more || ((phase_reg == PH_POST) && have_head);
            shift_ctl.push = ((phase_reg == PH_PRE) && !at_pos && !merge_prev) ||
                             pos_new || ((phase_reg == PH_MERGE) && !merge_more) ||
                             ((phase_reg == PH_POST) && have_head);
            if (pos_new)
            begin
                push_s = ins_s_reg;
                push_e = ins_e_reg;
            end
            else if (phase_reg == PH_MERGE)
            begin
                push_s = acc_s_reg;
                push_e = acc_e_reg;
            end
        end
        else if (out_load && (occ_reg != '0))
        begin
            // report rotates the ring once
            shift_ctl.pop  = 1'b1;
            shift_ctl.push = 1'b1;
        end

        if (merge_prev)
        begin
            acc_s_next = head_s;
            acc_e_next = (head_e > ins_e_reg) ? head_e : ins_e_reg;
        end
        else if (pos_merge)
        begin
            acc_s_next = ins_s_reg;
            acc_e_next = (head_e > ins_e_reg) ? head_e : ins_e_reg;
        end
        else if (merge_more)
        begin
            acc_e_next = (head_e > acc_e_reg) ? head_e : acc_e_reg;
        end

        if (pos_drop)
            ovf_next = 1'b1;

        if (ins_fire)
        begin
            ins_s_next = new_start;
            ins_e_next = new_end;
            ovf_next   = 1'b0;
            rem_next   = occ_reg;
        end
        else if (in_build && shift_ctl.pop)
        begin
            rem_next = rem_reg - ONE_C;
        end

        if (build_done)
            rpt_next = '0;
        else if (out_load)
            rpt_next = rpt_reg + ONE_C;

        if (clr_fire)
            occ_next = '0;
        else
            occ_next = occ_reg - {{(CW-1){1'b0}}, shift_ctl.pop}
                               + {{(CW-1){1'b0}}, shift_ctl.push};
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_s_next     = out_s_reg;
        out_e_next     = out_e_reg;
        out_ev_next    = out_ev_reg;
        out_last_next  = out_last_reg;
        out_ovf_next   = out_ovf_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_last_next  = rpt_last;
            out_ovf_next   = ovf_reg;
            if (occ_reg == '0)
            begin
                out_s_next  = '0;
                out_e_next  = '0;
                out_ev_next = 1'b0;
            end
            else
            begin
                out_s_next  = head_s;
                out_e_next  = head_e;
                out_ev_next = 1'b1;
            end
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_PRE;
            rem_reg       <= '0;
            occ_reg       <= '0;
            rpt_reg       <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            rem_reg       <= rem_next;
            occ_reg       <= occ_next;
            rpt_reg       <= rpt_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ins_s_reg    <= ins_s_next;
        ins_e_reg    <= ins_e_next;
        acc_s_reg    <= acc_s_next;
        acc_e_reg    <= acc_e_next;
        out_s_reg    <= out_s_next;
        out_e_reg    <= out_e_next;
        out_ev_reg   <= out_ev_next;
        out_last_reg <= out_last_next;
        out_ovf_reg  <= out_ovf_next;
    end

    assign out_valid   = out_valid_reg;
    assign out_start   = out_s_reg;
    assign out_end     = out_e_reg;
    assign entry_valid = out_ev_reg;
    assign last_entry  = out_last_reg;
    assign overflow    = out_ovf_reg;

`ifndef SYNTHESIS
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= DEPTH_C)
        else $error("table occupancy beyond depth");

    a_report_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_REPORT) |-> (rem_reg == '0))
        else $error("report started with old entries left in the ring");

    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_REPORT) && ovf_reg) |-> (occ_reg == DEPTH_C))
        else $error("insert dropped while table not full");

    a_pre_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_BUILD) && (phase_reg == PH_PRE) && !at_pos && !merge_prev)
            |=> (occ_reg == $past(occ_reg)))
        else $error("count changed while copying entries below insert point");
`endif

endmodule

@@ hw/rtl/iim_cell.sv @@
// ----------------------------------------------------------------------------
// iim_cell
// One slot of the interval ring: shifts toward the head on a pop and takes
// the pushed entry when it sits at the tail of the occupied region.
// ----------------------------------------------------------------------------
module iim_cell
    import iim_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
)
(
    input  logic                          clk,
    input  iim_shift_t                    ctl,
    input  logic                          occ_left,
    input  logic                          occ_self,
    input  logic                          occ_right,
    input  logic signed [VALUE_WIDTH-1:0] next_s,
    input  logic signed [VALUE_WIDTH-1:0] next_e,
    input  logic signed [VALUE_WIDTH-1:0] push_s,
    input  logic signed [VALUE_WIDTH-1:0] push_e,
    output logic signed [VALUE_WIDTH-1:0] cell_s,
    output logic signed [VALUE_WIDTH-1:0] cell_e
);

    logic signed [VALUE_WIDTH-1:0] s_reg;
    logic signed [VALUE_WIDTH-1:0] e_reg;
    logic                          tail;
    logic                          take_push;

    // tail slot after this cycle's shift
    assign tail      = ctl.pop ? (occ_self & ~occ_right) : (~occ_self & occ_left);
    assign take_push = ctl.push & tail;

    always_ff @(posedge clk)
    begin
        if (take_push)
        begin
            s_reg <= push_s;
            e_reg <= push_e;
        end
        else if (ctl.pop)
        begin
            s_reg <= next_s;
            e_reg <= next_e;
        end
    end

    assign cell_s = s_reg;
    assign cell_e = e_reg;

endmodule
